// ===== design/bn_pkg.sv =====
// Shared constants, widths and the datapath command codes for batch_norm_inference.
// No dependencies; every other design file imports this package.
package bn_pkg;

   // Number of channel entries in each parameter store
   localparam int CHANNELS   = 4;

   // Field widths
   localparam int CHAN_W     = 2;
   localparam int DATA_W     = 16;   // signed Q8.8
   localparam int VAR_W      = 24;   // unsigned Q8.16
   localparam int SUM_W      = VAR_W + 1;

   // Inverse square root arithmetic: floor(2^48 / S), then integer square root
   localparam int QUO_W      = 49;
   localparam int RAD_W      = QUO_W + 1;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SREM_W     = ROOT_W + 1;
   localparam int DIV_STEPS  = QUO_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int STEP_W     = 6;

   // Sample arithmetic widths
   localparam int DIFF_W     = DATA_W + 1;
   localparam int GD_W       = DATA_W + DIFF_W;
   localparam int HALF_W     = VAR_W / 2;
   localparam int PART_W     = GD_W + HALF_W + 1;
   localparam int ACC_W      = 59;
   localparam int FRAC_SH    = 24;
   localparam int RES_W      = ACC_W - FRAC_SH;

   localparam logic [VAR_W-1:0]  INV_MAX = {VAR_W{1'b1}};
   localparam logic [VAR_W-1:0]  EPS_RESET = VAR_W'(1);
   localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(32767);
   localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(32768);

   // Item opcodes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Commands from the controller to the datapath
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_PROD,
      CMD_SUM,
      CMD_DIV,
      CMD_SQRT_INIT,
      CMD_SQRT,
      CMD_STORE
   } dp_cmd_type;

endpackage

// ===== design/bn_req_if.sv =====
// Input channel of batch_norm_inference: valid/ready handshake plus item payload.
// Depends on bn_pkg for field widths.
interface bn_req_if;
   import bn_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [CHAN_W-1:0]        channel;
   logic signed [DATA_W-1:0] sample;
   logic signed [DATA_W-1:0] scale_in;
   logic signed [DATA_W-1:0] shift_in;
   logic signed [DATA_W-1:0] mean_in;
   logic [VAR_W-1:0]         variance_in;

   modport source (
      output valid, op, channel, sample, scale_in, shift_in, mean_in, variance_in,
      input  ready
   );

   modport sink (
      input  valid, op, channel, sample, scale_in, shift_in, mean_in, variance_in,
      output ready
   );

endinterface

// ===== design/bn_rsp_if.sv =====
// Result channel of batch_norm_inference: valid/ready handshake plus result payload.
// Depends on bn_pkg for field widths.
interface bn_rsp_if;
   import bn_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_value;
   logic [CHAN_W-1:0]        out_channel;

   modport source (
      output valid, out_value, out_channel,
      input  ready
   );

   modport sink (
      input  valid, out_value, out_channel,
      output ready
   );

endinterface

// ===== design/bn_datapath.sv =====
// Datapath: epsilon register, per-channel parameter stores, the sample multiply/round
// path and the bit-serial divider and square root for the inverse std. Uses bn_pkg.
module bn_datapath
   import bn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic                     csr_wr_en,
   input  logic [VAR_W-1:0]         csr_wr_data,
   input  logic [CHAN_W-1:0]        channel,
   input  logic signed [DATA_W-1:0] sample,
   input  logic signed [DATA_W-1:0] scale_in,
   input  logic signed [DATA_W-1:0] shift_in,
   input  logic signed [DATA_W-1:0] mean_in,
   input  logic [VAR_W-1:0]         variance_in,
   output logic signed [DATA_W-1:0] out_value,
   output logic [CHAN_W-1:0]        out_channel
);

   // Configuration and per-channel stores
   logic [VAR_W-1:0]         eps_ff;
   logic signed [DATA_W-1:0] scale_mem_ff [CHANNELS];
   logic signed [DATA_W-1:0] shift_mem_ff [CHANNELS];
   logic signed [DATA_W-1:0] mean_mem_ff  [CHANNELS];
   logic [VAR_W-1:0]         inv_mem_ff   [CHANNELS];

   // Captured item
   logic [CHAN_W-1:0]        ch_ff;
   logic                     ch_ok_ff;
   logic signed [DATA_W-1:0] ld_scale_ff;
   logic signed [DATA_W-1:0] ld_shift_ff;
   logic signed [DATA_W-1:0] ld_mean_ff;

   // Sample path
   logic signed [GD_W-1:0]   gd_ff;
   logic signed [DATA_W-1:0] beta_ff;
   logic [VAR_W-1:0]         inv_ff;
   logic signed [PART_W-1:0] p_lo_ff;
   logic signed [PART_W-1:0] p_hi_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   logic [CHAN_W-1:0]        out_channel_ff;

   // Divider and square root
   logic [SUM_W-1:0]         sum_s_ff;
   logic [SUM_W-1:0]         rem_ff;
   logic [QUO_W-1:0]         quo_ff;
   logic [RAD_W-1:0]         rad_ff;
   logic [SREM_W-1:0]        srem_ff;
   logic [ROOT_W-1:0]        root_ff;

   logic                     ch_ok;
   logic signed [DATA_W-1:0] gamma_rd;
   logic signed [DATA_W-1:0] mean_rd;
   logic signed [DATA_W-1:0] beta_rd;
   logic [VAR_W-1:0]         inv_rd;
   logic signed [DIFF_W-1:0] diff;
   logic signed [GD_W-1:0]   gd;
   logic signed [ACC_W-1:0]  acc;
   logic signed [RES_W-1:0]  res;
   logic signed [DATA_W-1:0] res_sat;
   logic [SUM_W:0]           div_shifted;
   logic                     div_ge;
   logic [SREM_W+1:0]        sq_cand;
   logic [ROOT_W+1:0]        sq_trial;
   logic                     sq_ge;
   logic [VAR_W-1:0]         inv_new;

   // Store read at accept time; an out-of-range channel reads as zero
   always_comb begin
      ch_ok    = int'(channel) < CHANNELS;
      gamma_rd = ch_ok ? scale_mem_ff[channel] : '0;
      mean_rd  = ch_ok ? mean_mem_ff[channel]  : '0;
      beta_rd  = ch_ok ? shift_mem_ff[channel] : '0;
      inv_rd   = ch_ok ? inv_mem_ff[channel]   : '0;
      diff     = DIFF_W'(sample) - DIFF_W'(mean_rd);
      gd       = GD_W'(diff) * GD_W'(gamma_rd);
   end

   // Final sum, round to nearest (ties up) and saturate
   always_comb begin
      acc = (ACC_W'(p_hi_ff) <<< HALF_W) + ACC_W'(p_lo_ff)
          + (ACC_W'(beta_ff) <<< FRAC_SH) + (ACC_W'(1) <<< (FRAC_SH - 1));
      res = acc[ACC_W-1:FRAC_SH];
      priority if (res > OUT_MAX) begin
         res_sat = DATA_W'(OUT_MAX);
      end else if (res < OUT_MIN) begin
         res_sat = DATA_W'(OUT_MIN);
      end else begin
         res_sat = res[DATA_W-1:0];
      end
   end

   // One restoring division step and one square root digit step
   always_comb begin
      div_shifted = {rem_ff, quo_ff[QUO_W-1]};
      div_ge      = div_shifted >= {1'b0, sum_s_ff};
      sq_cand     = {srem_ff, rad_ff[RAD_W-1 -: 2]};
      sq_trial    = {root_ff, 2'b01};
      sq_ge       = sq_cand >= {1'b0, sq_trial};
      inv_new     = root_ff[ROOT_W-1] ? INV_MAX : root_ff[VAR_W-1:0];
   end

   // Epsilon register and parameter stores
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
         for (int i = 0; i < CHANNELS; i++) begin
            scale_mem_ff[i] <= '0;
            shift_mem_ff[i] <= '0;
            mean_mem_ff[i]  <= '0;
            inv_mem_ff[i]   <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            eps_ff <= csr_wr_data;
         end
         if (cmd == CMD_STORE && ch_ok_ff) begin
            scale_mem_ff[ch_ff] <= ld_scale_ff;
            shift_mem_ff[ch_ff] <= ld_shift_ff;
            mean_mem_ff[ch_ff]  <= ld_mean_ff;
            inv_mem_ff[ch_ff]   <= inv_new;
         end
      end
   end

   // Working registers, sequenced by the controller
   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_ACCEPT: begin
            ch_ff       <= channel;
            ch_ok_ff    <= ch_ok;
            ld_scale_ff <= scale_in;
            ld_shift_ff <= shift_in;
            ld_mean_ff  <= mean_in;
            gd_ff       <= gd;
            beta_ff     <= beta_rd;
            inv_ff      <= inv_rd;
            sum_s_ff    <= SUM_W'(variance_in) + SUM_W'(eps_ff);
            rem_ff      <= '0;
            quo_ff      <= {1'b1, {(QUO_W-1){1'b0}}};
         end
         CMD_PROD: begin
            p_lo_ff <= PART_W'(gd_ff) * PART_W'($signed({1'b0, inv_ff[HALF_W-1:0]}));
            p_hi_ff <= PART_W'(gd_ff) * PART_W'($signed({1'b0, inv_ff[VAR_W-1:HALF_W]}));
         end
         CMD_SUM: begin
            out_value_ff   <= ch_ok_ff ? res_sat : '0;
            out_channel_ff <= ch_ff;
         end
         CMD_DIV: begin
            rem_ff <= div_ge ? SUM_W'(div_shifted - {1'b0, sum_s_ff})
                             : div_shifted[SUM_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], div_ge};
         end
         CMD_SQRT_INIT: begin
            rad_ff  <= {1'b0, quo_ff};
            srem_ff <= '0;
            root_ff <= '0;
         end
         CMD_SQRT: begin
            srem_ff <= sq_ge ? SREM_W'(sq_cand - {1'b0, sq_trial})
                             : sq_cand[SREM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
            rad_ff  <= rad_ff << 2;
         end
         CMD_NONE, CMD_STORE: begin
         end
         default: begin
         end
      endcase
   end

   assign out_value   = out_value_ff;
   assign out_channel = out_channel_ff;

endmodule

// ===== design/bn_ctrl.sv =====
// Controller: accepts one transaction at a time and steps the datapath through the
// sample path or the divide/square-root sequence of a load. Uses bn_pkg.
module bn_ctrl
   import bn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROD,
      S_SUM,
      S_RESP,
      S_DIV,
      S_SQRT_INIT,
      S_SQRT,
      S_STORE
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic              req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Command decode
   always_comb begin
      unique case (state_ff)
         S_IDLE:      cmd = req_fire ? CMD_ACCEPT : CMD_NONE;
         S_PROD:      cmd = CMD_PROD;
         S_SUM:       cmd = CMD_SUM;
         S_RESP:      cmd = CMD_NONE;
         S_DIV:       cmd = CMD_DIV;
         S_SQRT_INIT: cmd = CMD_SQRT_INIT;
         S_SQRT:      cmd = CMD_SQRT;
         S_STORE:     cmd = CMD_STORE;
         default:     cmd = CMD_NONE;
      endcase
   end

   // State, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               if (req_fire) begin
                  state_ff <= (req_op == OP_SAMPLE) ? S_PROD : S_DIV;
               end
            end
            S_PROD: state_ff <= S_SUM;
            S_SUM: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_DIV: begin
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_SQRT_INIT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_SQRT_INIT: state_ff <= S_SQRT;
            S_SQRT: begin
               if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
                  step_ff  <= '0;
                  state_ff <= S_STORE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_STORE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Only one transaction in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("bn_ctrl: input accepted while busy");

   // A load raises no result while its first division steps run
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_LOAD) |=> !rsp_valid ##1 !rsp_valid)
      else $error("bn_ctrl: result raised during a load");

   // Result valid only while waiting in the response state
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_RESP)
      else $error("bn_ctrl: result valid outside response state");

   // Iteration counter stays inside the division range
   a_div_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> step_ff < STEP_W'(DIV_STEPS))
      else $error("bn_ctrl: divider step out of range");

   // A delivered result frees the block for the next transaction
   a_rsp_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready && !rsp_valid)
      else $error("bn_ctrl: block not idle after result taken");

endmodule

// ===== design/batch_norm_inference.sv =====
// Batch normalization for inference on a sample stream with per-channel parameters.
// One transaction is processed at a time. A sample transaction (op 1) returns
// gamma*((sample-mean)*inv_std)+beta for its channel, rounded to nearest Q8.8 and
// saturated. The subtract/multiply stage registers at the accepting edge, then the
// split multiply and sum/round stages follow, and the sum/round stage offers the
// result. The block accepts again only after the result has been taken, so it takes
// no new sample while one is in flight. A load transaction (op 0) stores gamma,
// beta and the mean and computes inv_std = floor(2^24/sqrt(var+epsilon)) in
// unsigned Q8.16, saturating at 0xFFFFFF; it produces no result and the block
// accepts again only after 49 steps of the one-bit-per-cycle divider, 25 steps of
// the square root unit, plus the set-up and store states. The epsilon register
// (reset value 1) is written through csr_wr_en/csr_wr_data; the user must write it
// only while the block is idle (the block itself does not enforce this). A write
// affects only later loads. Stores are cleared at reset.
module batch_norm_inference
   import bn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [VAR_W-1:0] csr_wr_data,
   bn_req_if.sink           req_chan,
   bn_rsp_if.source         rsp_chan
);

   dp_cmd_type cmd;

   // Sequencer
   bn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Arithmetic and stores
   bn_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .channel     (req_chan.channel),
      .sample      (req_chan.sample),
      .scale_in    (req_chan.scale_in),
      .shift_in    (req_chan.shift_in),
      .mean_in     (req_chan.mean_in),
      .variance_in (req_chan.variance_in),
      .out_value   (rsp_chan.out_value),
      .out_channel (rsp_chan.out_channel)
   );

endmodule
